// ===== src/generational_handle_slot_table_defines.svh =====
// Assertion macros for the generational handle slot table.
// Included by the top level, which carries the concurrent checks; expects clk and rst_n in scope.
`ifndef GENERATIONAL_HANDLE_SLOT_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define GHST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define GHST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ghst_pkg.sv =====
// Shared types and codes of the generational handle slot table.
// No dependencies; imported by the top level.
package ghst_pkg;

  // Request codes carried in the input tuser
  localparam logic [2:0] MODE_ALLOC   = 3'd0;
  localparam logic [2:0] MODE_SUB     = 3'd1;
  localparam logic [2:0] MODE_UNSUB   = 3'd2;
  localparam logic [2:0] MODE_RELEASE = 3'd3;
  localparam logic [2:0] MODE_LOOKUP  = 3'd4;

  // Asset kinds
  localparam logic [2:0] KIND_IMAGE = 3'd0;
  localparam logic [2:0] KIND_FONT  = 3'd3;

  // Port field widths
  localparam int unsigned IDX_PORT_W   = 8;
  localparam int unsigned GEN_PORT_W   = 16;
  localparam int unsigned CNT_PORT_W   = 16;
  localparam int unsigned ASSET_PORT_W = 16;
  localparam int unsigned IN_DATA_W    = 48;
  localparam int unsigned OUT_DATA_W   = 64;

  // Slots per group in the free-slot search
  localparam int unsigned GRP_SIZE = 8;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_RANGE    = 4'd1,
    ST_STALE    = 4'd2,
    ST_EMPTY    = 4'd3,
    ST_UNDER    = 4'd4,
    ST_REFD     = 4'd5,
    ST_KIND     = 4'd6,
    ST_NOASSET  = 4'd7,
    ST_MISMATCH = 4'd8,
    ST_CREATE   = 4'd9,
    ST_FULL     = 4'd10,
    ST_UNIMPL   = 4'd11,
    ST_SAT      = 4'd12
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_t;

endpackage

// ===== src/generational_handle_slot_table.sv =====
// Generational handle slot table: top level with the slot memory and request sequencer.
// Depends on ghst_pkg and generational_handle_slot_table_defines.svh.
//
// Usage:
//   One request per input transfer: in_tuser holds the request code (allocate,
//   subscribe, unsubscribe, release, lookup) and in_tdata its operands. Every
//   request answers with exactly one result transfer on the out_ channel.
//   out_tvalid rises at the edge that ends the update state; the request and
//   its slot word are registered at accept first. A new request is taken only
//   once the previous one has been updated. This is set by the slot memory: the
//   request reads its slot at accept and the update state checks, updates and
//   writes the slot back before the next read.
//   Allocate takes the lowest free slot, found from per-group free flags that
//   are registered alongside the occupancy bits.
//   After reset every slot is free with generation 1 and count 0; entries of the
//   slot memory read as that until first written, so no clearing pass is run and
//   requests are taken in the first cycle after reset.
//   The result sits in an output register; one request may be accepted while a
//   result waits, and its update stalls until out_tready takes the older result.
`include "generational_handle_slot_table_defines.svh"

module generational_handle_slot_table
  import ghst_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = 64,
  parameter int unsigned GEN_BITS   = 16,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned ASSET_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] slot_index, [23:8] handle_generation, [26:24] asset_kind,
  // [27] asset_present, [28] asset_is_image, [29] create_ok, [45:30] asset_ref
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] mode
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [3:0] status, [11:4] result_index, [27:12] result_generation, [28] alive,
  // [44:29] ref_count, [45] freed_valid, [61:46] freed_asset_ref, [62] table_empty
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned NGRP   = (NUM_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned SRCH_W = GRP_W + 3;
  localparam int unsigned HW     = (GEN_BITS > GEN_PORT_W) ? GEN_BITS : GEN_PORT_W;
  localparam int unsigned CMP_W  = IDX_PORT_W + 1;
  localparam int unsigned WORD_W = ASSET_BITS + GEN_BITS + COUNT_BITS;
  localparam logic [GEN_BITS-1:0]   GEN_RST = GEN_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Sequencer
  fsm_t state_r, state_nxt;
  logic accept, exec_go;

  // Request captured at accept
  logic [2:0]              mode_r;
  logic [IDX_PORT_W-1:0]   idx_r;
  logic [GEN_PORT_W-1:0]   hgen_r;
  logic [2:0]              kind_r;
  logic                    present_r, is_image_r, create_ok_r;
  logic [ASSET_PORT_W-1:0] aref_r;
  logic [IDX_W-1:0]        addr_r;
  logic                    full_r;
  logic                    occ_hit_r;
  logic                    gvalid_hit_r;

  // Slot memory: {asset, generation, count}
  logic [WORD_W-1:0] slot_mem [NUM_SLOTS];
  logic [WORD_W-1:0] rd_word_r;
  logic [IDX_W-1:0]  rd_addr;

  // Per-slot flags and counters
  logic [NUM_SLOTS-1:0] occ_r, occ_nxt;
  logic [NUM_SLOTS-1:0] gvalid_r;
  logic [CNT_W-1:0]     created_r, created_nxt;
  logic [CNT_W-1:0]     total_r, total_nxt;

  // Free-slot search
  logic [NGRP*GRP_SIZE-1:0] occ_pad;
  logic [NGRP-1:0]          grp_free_r, grp_free_nxt;
  logic [2:0]               grp_off_r [NGRP];
  logic [2:0]               grp_off_nxt [NGRP];
  logic                     free_any;
  logic [SRCH_W-1:0]        free_pos;
  logic [IDX_W-1:0]         free_idx;

  // Update results
  status_t                st_v;
  logic [GEN_BITS-1:0]    gen_cur, gen_new;
  logic [COUNT_BITS-1:0]  cnt_cur, cnt_new;
  logic [ASSET_BITS-1:0]  asset_cur, asset_new;
  logic                   occ_new, show, alive_v, freed_v;
  logic                   mem_we, occ_we, tot_inc, tot_dec, alloc_ok;
  logic [IDX_PORT_W-1:0]  res_idx;

  // Output register
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance when a request is taken; hold the update while the output is blocked
  always_comb begin
    state_nxt = state_r;
    exec_go   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!out_tvalid_r || out_tready) begin
          exec_go   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Pick the lowest free slot from the registered group flags
  always_comb begin
    free_any = |grp_free_r;
    free_pos = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_free_r[g]) free_pos = {GRP_W'(g), grp_off_r[g]};
    end
  end
  assign free_idx = free_pos[IDX_W-1:0];
  assign rd_addr  = (in_tuser == MODE_ALLOC) ? free_idx : in_tdata[IDX_W-1:0];

  // Capture the request and read its slot
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r       <= in_tuser;
      idx_r        <= in_tdata[7:0];
      hgen_r       <= in_tdata[23:8];
      kind_r       <= in_tdata[26:24];
      present_r    <= in_tdata[27];
      is_image_r   <= in_tdata[28];
      create_ok_r  <= in_tdata[29];
      aref_r       <= in_tdata[45:30];
      addr_r       <= rd_addr;
      full_r       <= !free_any;
      occ_hit_r    <= occ_r[rd_addr];
      gvalid_hit_r <= gvalid_r[rd_addr];
      rd_word_r    <= slot_mem[rd_addr];
    end
  end

  // Write the slot back
  always_ff @(posedge clk) begin
    if (exec_go && mem_we) begin
      slot_mem[addr_r] <= {asset_new, gen_new, cnt_new};
    end
  end

  // Check the request and work out the new slot contents
  always_comb begin
    gen_cur   = gvalid_hit_r ? rd_word_r[COUNT_BITS +: GEN_BITS] : GEN_RST;
    cnt_cur   = gvalid_hit_r ? rd_word_r[COUNT_BITS-1:0] : '0;
    asset_cur = rd_word_r[WORD_W-1 -: ASSET_BITS];
    st_v      = ST_OK;
    gen_new   = gen_cur;
    cnt_new   = cnt_cur;
    asset_new = asset_cur;
    occ_new   = occ_hit_r;
    res_idx   = '0;
    show      = 1'b0;
    alive_v   = 1'b0;
    freed_v   = 1'b0;
    mem_we    = 1'b0;
    occ_we    = 1'b0;
    tot_inc   = 1'b0;
    tot_dec   = 1'b0;
    alloc_ok  = 1'b0;
    case (mode_r)
      MODE_ALLOC: begin
        if (kind_r > KIND_FONT)        st_v = ST_KIND;
        else if (!present_r)           st_v = ST_NOASSET;
        else if (full_r)               st_v = ST_FULL;
        else if (kind_r != KIND_IMAGE) st_v = ST_UNIMPL;
        else if (!is_image_r)          st_v = ST_MISMATCH;
        else if (!create_ok_r)         st_v = ST_CREATE;
        else begin
          alloc_ok  = 1'b1;
          occ_new   = 1'b1;
          cnt_new   = COUNT_BITS'(1);
          asset_new = ASSET_BITS'(aref_r);
          mem_we    = 1'b1;
          occ_we    = 1'b1;
          tot_inc   = 1'b1;
          res_idx   = IDX_PORT_W'(addr_r);
          show      = 1'b1;
          alive_v   = 1'b1;
        end
      end
      MODE_SUB, MODE_UNSUB, MODE_RELEASE, MODE_LOOKUP: begin
        res_idx = idx_r;
        if ({1'b0, idx_r} >= CMP_W'(created_r)) begin
          st_v = ST_RANGE;
        end else begin
          show = 1'b1;
          if (HW'(hgen_r) != HW'(gen_cur)) st_v = ST_STALE;
          else if (!occ_hit_r)             st_v = ST_EMPTY;
          else begin
            case (mode_r)
              MODE_SUB: begin
                if (cnt_cur == CNT_MAX) st_v = ST_SAT;
                else begin
                  cnt_new = cnt_cur + COUNT_BITS'(1);
                  mem_we  = 1'b1;
                end
              end
              MODE_UNSUB: begin
                if (cnt_cur == '0) st_v = ST_UNDER;
                else begin
                  cnt_new = cnt_cur - COUNT_BITS'(1);
                  mem_we  = 1'b1;
                end
              end
              MODE_RELEASE: begin
                if (cnt_cur != '0) st_v = ST_REFD;
                else begin
                  occ_new = 1'b0;
                  gen_new = gen_cur + GEN_BITS'(1);
                  mem_we  = 1'b1;
                  occ_we  = 1'b1;
                  tot_dec = (total_r != '0);
                  freed_v = 1'b1;
                end
              end
              default: ;
            endcase
          end
          alive_v = occ_new && (HW'(hgen_r) == HW'(gen_new));
        end
      end
      default: st_v = ST_RANGE;
    endcase
  end

  // Next values of the occupancy bits and counters
  always_comb begin
    occ_nxt     = occ_r;
    created_nxt = created_r;
    total_nxt   = total_r;
    if (exec_go) begin
      if (occ_we) occ_nxt[addr_r] = occ_new;
      if (alloc_ok && (CNT_W'(addr_r) + CNT_W'(1) > created_r)) begin
        created_nxt = CNT_W'(addr_r) + CNT_W'(1);
      end
      if (tot_inc)      total_nxt = total_r + CNT_W'(1);
      else if (tot_dec) total_nxt = total_r - CNT_W'(1);
    end
  end

  // Group free flags follow the next occupancy, so they are current with it
  always_comb begin
    occ_pad = '1;
    occ_pad[NUM_SLOTS-1:0] = occ_nxt;
    for (int g = 0; g < NGRP; g++) begin
      grp_free_nxt[g] = ~&occ_pad[g*GRP_SIZE +: GRP_SIZE];
      grp_off_nxt[g]  = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (!occ_pad[g*GRP_SIZE + b]) grp_off_nxt[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= '0;
      gvalid_r   <= '0;
      created_r  <= '0;
      total_r    <= '0;
      grp_free_r <= '1;
      for (int g = 0; g < NGRP; g++) grp_off_r[g] <= '0;
    end else begin
      occ_r      <= occ_nxt;
      created_r  <= created_nxt;
      total_r    <= total_nxt;
      grp_free_r <= grp_free_nxt;
      for (int g = 0; g < NGRP; g++) grp_off_r[g] <= grp_off_nxt[g];
      if (exec_go && mem_we) gvalid_r[addr_r] <= 1'b1;
    end
  end

  // Assemble the result and hold it until transferred
  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    if (exec_go) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {1'b0,
                        (total_nxt == '0),
                        freed_v ? ASSET_PORT_W'(asset_cur) : '0,
                        freed_v,
                        show ? CNT_PORT_W'(cnt_new) : '0,
                        alive_v,
                        show ? GEN_PORT_W'(gen_new) : '0,
                        res_idx,
                        st_v};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  // Checks
  `GHST_ASSERT_IMP(a_total_tracks_occ, 1'b1, total_r == CNT_W'($countones(occ_r)), "occupied total out of step with occupancy")
  `GHST_ASSERT_IMP(a_free_flags_current, 1'b1, (|grp_free_r) == (|(~occ_r)), "group free flags stale")
  `GHST_ASSERT_NXT(a_alloc_marks_slot, exec_go && alloc_ok, occ_r[addr_r] && (created_r > CNT_W'(addr_r)), "allocated slot not marked")
  `GHST_ASSERT_NXT(a_created_grows, 1'b1, created_r >= $past(created_r), "slot range shrank")

endmodule
